[hw/rtl/cos_sim_pkg.sv]
// Shared types and constants of the cosine similarity unit.
// Used by the front end, the sums queue, the back end and the top level.
package cos_sim_pkg;

   localparam int ElemPortW = 16;
   localparam int DotW      = 44;
   localparam int NormW     = 43;
   localparam int SimW      = 16;
   // Magnitude of the quotient: 0 to 16384 needs fifteen bits.
   localparam int QW        = 15;
   localparam int HalfW     = 22;
   localparam int ProdW     = 2 * HalfW;
   localparam int WideW     = 2 * ProdW;
   localparam int FracShift = 28;
   localparam int CmpW      = 117;
   localparam int StepW     = 4;
   localparam int KW        = 4;

   localparam logic [StepW-1:0] MulIssue = 4'd8;
   localparam logic [StepW-1:0] MulDone  = 4'd9;
   localparam logic [KW-1:0]    TopBit   = 4'd14;

   localparam int FifoDepth = 2;
   localparam int FifoPtrW  = 1;
   localparam int FifoCntW  = 2;

   localparam logic signed [DotW-1:0] DotMax  = {1'b0, {(DotW-1){1'b1}}};
   localparam logic signed [DotW-1:0] DotMin  = {1'b1, {(DotW-1){1'b0}}};
   localparam logic [NormW-1:0]       NormMax = {NormW{1'b1}};
   localparam logic signed [SimW-1:0] SimOne  = 16'sd16384;

   typedef struct packed {
      logic signed [DotW-1:0] dot;
      logic [NormW-1:0]       norm_a;
      logic [NormW-1:0]       norm_b;
   } vec_sums_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_CMP,
      ST_RESULT
   } back_state_type;

endpackage

[hw/rtl/cos_sim_front.sv]
// Front end: takes element pair beats, squares and multiplies them, and keeps
// the saturating running sums. Depends on cos_sim_pkg.
module cos_sim_front #(
   parameter int ELEM_WIDTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [15:0]              req_elem_a,
   input  logic signed [15:0]              req_elem_b,
   input  logic                            req_last_elem,
   output logic                            push,
   input  logic                            fifo_full,
   output cos_sim_pkg::vec_sums_type       push_data
);
   import cos_sim_pkg::*;

   localparam int PW   = 2 * ELEM_WIDTH;
   localparam int AccW = ((PW > DotW) ? PW : DotW) + 1;

   logic signed [ELEM_WIDTH-1:0] a, b;
   logic                         take, stall;

   logic signed [PW-1:0]   dot_p_ff, dot_p_in;
   logic signed [PW-1:0]   sqa_ff, sqa_in;
   logic signed [PW-1:0]   sqb_ff, sqb_in;
   logic                   last_ff, last_in;
   logic                   vld_ff, vld_in;

   logic signed [DotW-1:0] dot_acc_ff, dot_acc_in;
   logic [NormW-1:0]       na_acc_ff, na_acc_in;
   logic [NormW-1:0]       nb_acc_ff, nb_acc_in;

   logic signed [AccW-1:0] dot_s, na_s, nb_s;
   logic signed [DotW-1:0] dot_sat;
   logic [NormW-1:0]       na_sat, nb_sat;

   // Only the low ELEM_WIDTH bits of a wider field carry the element; a narrower port is zero-extended.
   if (ELEM_WIDTH <= ElemPortW) begin : g_sext
      assign a = req_elem_a[ELEM_WIDTH-1:0];
      assign b = req_elem_b[ELEM_WIDTH-1:0];
   end else begin : g_zext
      assign a = {{(ELEM_WIDTH-ElemPortW){1'b0}}, req_elem_a};
      assign b = {{(ELEM_WIDTH-ElemPortW){1'b0}}, req_elem_b};
   end

   // A last pair that cannot enter the queue holds the whole front end.
   assign stall     = vld_ff & last_ff & fifo_full;
   assign req_ready = ~stall;
   assign take      = req_valid & req_ready;

   always_comb begin
      vld_in   = stall ? vld_ff : take;
      dot_p_in = dot_p_ff;
      sqa_in   = sqa_ff;
      sqb_in   = sqb_ff;
      last_in  = last_ff;
      if (take) begin
         dot_p_in = PW'(a) * PW'(b);
         sqa_in   = PW'(a) * PW'(a);
         sqb_in   = PW'(b) * PW'(b);
         last_in  = req_last_elem;
      end
   end

   always_comb begin
      dot_s = AccW'(dot_acc_ff) + AccW'(dot_p_ff);
      na_s  = AccW'($signed({1'b0, na_acc_ff})) + AccW'(sqa_ff);
      nb_s  = AccW'($signed({1'b0, nb_acc_ff})) + AccW'(sqb_ff);

      priority if (dot_s > AccW'(DotMax)) begin
         dot_sat = DotMax;
      end else if (dot_s < AccW'(DotMin)) begin
         dot_sat = DotMin;
      end else begin
         dot_sat = dot_s[DotW-1:0];
      end
      na_sat = (na_s > AccW'($signed({1'b0, NormMax}))) ? NormMax : na_s[NormW-1:0];
      nb_sat = (nb_s > AccW'($signed({1'b0, NormMax}))) ? NormMax : nb_s[NormW-1:0];

      dot_acc_in = dot_acc_ff;
      na_acc_in  = na_acc_ff;
      nb_acc_in  = nb_acc_ff;
      if (vld_ff && !stall) begin
         if (last_ff) begin
            dot_acc_in = '0;
            na_acc_in  = '0;
            nb_acc_in  = '0;
         end else begin
            dot_acc_in = dot_sat;
            na_acc_in  = na_sat;
            nb_acc_in  = nb_sat;
         end
      end
   end

   assign push             = vld_ff & last_ff & ~fifo_full;
   assign push_data.dot    = dot_sat;
   assign push_data.norm_a = na_sat;
   assign push_data.norm_b = nb_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= 1'b0;
         dot_acc_ff <= '0;
         na_acc_ff  <= '0;
         nb_acc_ff  <= '0;
      end else begin
         vld_ff     <= vld_in;
         dot_acc_ff <= dot_acc_in;
         na_acc_ff  <= na_acc_in;
         nb_acc_ff  <= nb_acc_in;
      end
      dot_p_ff <= dot_p_in;
      sqa_ff   <= sqa_in;
      sqb_ff   <= sqb_in;
      last_ff  <= last_in;
   end

endmodule

[hw/rtl/cos_sim_fifo.sv]
// Two-entry queue of finished vector sums between the front and back ends.
// Depends on cos_sim_pkg.
module cos_sim_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  cos_sim_pkg::vec_sums_type push_data,
   input  logic                      pop,
   output cos_sim_pkg::vec_sums_type head,
   output logic                      not_empty,
   output logic                      full
);
   import cos_sim_pkg::*;

   vec_sums_type          entry_ff [FifoDepth];
   logic [FifoPtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FifoPtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FifoCntW-1:0]   count_ff, count_in;

   assign head      = entry_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == FifoCntW'(FifoDepth));

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("sums queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !not_empty))
      else $error("sums queue read while empty");
`endif

endmodule

[hw/rtl/cos_sim_back.sv]
// Back end: forms the norm product and squared dot with one shared 22x22
// multiplier, then finds the Q1.14 cosine bit by bit. Depends on cos_sim_pkg.
module cos_sim_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      fifo_valid,
   input  cos_sim_pkg::vec_sums_type fifo_head,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [15:0]        rsp_similarity,
   output logic                      rsp_degenerate
);
   import cos_sim_pkg::*;

   back_state_type state_ff, state_in;

   logic [StepW-1:0]  step_ff, step_in;
   logic              neg_ff, neg_in;
   logic [DotW-1:0]   mag_ff, mag_in;
   logic [NormW-1:0]  na_ff, na_in;
   logic [NormW-1:0]  nb_ff, nb_in;

   logic [ProdW-1:0]  pp_ff, pp_in;
   logic [2:0]        pp_sel_ff, pp_sel_in;
   logic              pp_vld_ff, pp_vld_in;
   logic [WideW-1:0]  p_ff, p_in;
   logic [WideW-1:0]  d_ff, d_in;

   logic [CmpW-1:0]   s_ff, s_in;
   logic [CmpW-1:0]   tsh_ff, tsh_in;
   logic [CmpW-1:0]   psh_ff, psh_in;
   logic [CmpW-1:0]   trial_ff, trial_in;
   logic [QW-1:0]     q_ff, q_in;
   logic [KW-1:0]     k_ff, k_in;
   logic              deg_ff, deg_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [SimW-1:0] rsp_sim_ff, rsp_sim_in;
   logic                   rsp_deg_ff, rsp_deg_in;

   logic [DotW-1:0]   x_op, y_op;
   logic [HalfW-1:0]  x_half, y_half;
   logic [WideW-1:0]  pp_shifted;
   logic [CmpW-1:0]   rhs;
   logic [SimW-1:0]   q_ext;
   logic              head_zero, accept, out_free;

   assign head_zero = (fifo_head.norm_a == '0) || (fifo_head.norm_b == '0);
   assign rhs       = CmpW'({d_ff, {FracShift{1'b0}}});
   // A trial is refused once the quotient has reached 1.0, which clamps it.
   assign accept    = (trial_ff <= rhs) && !q_ff[QW-1];
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign q_ext     = SimW'(q_ff);

   // Step bit 2 picks the product (norms or dot), bits 1 and 0 the halves.
   always_comb begin
      x_op   = step_ff[2] ? mag_ff : DotW'(na_ff);
      y_op   = step_ff[2] ? mag_ff : DotW'(nb_ff);
      x_half = step_ff[1] ? x_op[DotW-1:HalfW] : x_op[HalfW-1:0];
      y_half = step_ff[0] ? y_op[DotW-1:HalfW] : y_op[HalfW-1:0];
      unique case (pp_sel_ff[1:0])
         2'b00:   pp_shifted = WideW'(pp_ff);
         2'b11:   pp_shifted = WideW'(pp_ff) << (2 * HalfW);
         default: pp_shifted = WideW'(pp_ff) << HalfW;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (fifo_valid) begin
               state_in = head_zero ? ST_RESULT : ST_MUL;
            end
         end
         ST_MUL: begin
            if (step_ff == MulDone) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: state_in = ST_CMP;
         ST_CMP: state_in = (k_ff == '0) ? ST_RESULT : ST_ADD;
         ST_RESULT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pop          = 1'b0;
      step_in      = step_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      na_in        = na_ff;
      nb_in        = nb_ff;
      pp_in        = x_half * y_half;
      pp_sel_in    = step_ff[2:0];
      pp_vld_in    = 1'b0;
      p_in         = p_ff;
      d_in         = d_ff;
      s_in         = s_ff;
      tsh_in       = tsh_ff;
      psh_in       = psh_ff;
      trial_in     = trial_ff;
      q_in         = q_ff;
      k_in         = k_ff;
      deg_in       = deg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_sim_in   = rsp_sim_ff;
      rsp_deg_in   = rsp_deg_ff;

      if (pp_vld_ff) begin
         if (pp_sel_ff[2]) begin
            d_in = d_ff + pp_shifted;
         end else begin
            p_in = p_ff + pp_shifted;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (fifo_valid) begin
               pop    = 1'b1;
               neg_in = fifo_head.dot[DotW-1];
               mag_in = fifo_head.dot[DotW-1] ? DotW'(-$unsigned(fifo_head.dot))
                                              : DotW'($unsigned(fifo_head.dot));
               na_in   = fifo_head.norm_a;
               nb_in   = fifo_head.norm_b;
               deg_in  = head_zero;
               q_in    = '0;
               step_in = '0;
               p_in    = '0;
               d_in    = '0;
            end
         end
         ST_MUL: begin
            step_in   = step_ff + 1'b1;
            pp_vld_in = (step_ff < MulIssue);
            if (step_ff == MulDone) begin
               s_in   = '0;
               tsh_in = '0;
               psh_in = CmpW'({p_ff, {FracShift{1'b0}}});
               q_in   = '0;
               k_in   = TopBit;
            end
         end
         ST_ADD: begin
            trial_in = s_ff + tsh_ff + psh_ff;
         end
         ST_CMP: begin
            // The shifted copies of q*P and P follow the trial bit down.
            psh_in = psh_ff >> 2;
            k_in   = k_ff - 1'b1;
            if (accept) begin
               s_in   = trial_ff;
               tsh_in = (tsh_ff >> 1) + psh_ff;
               q_in   = q_ff | (QW'(1) << k_ff);
            end else begin
               tsh_in = tsh_ff >> 1;
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_sim_in   = neg_ff ? -q_ext : q_ext;
               rsp_deg_in   = deg_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         k_ff         <= '0;
         pp_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         k_ff         <= k_in;
         pp_vld_ff    <= pp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff     <= neg_in;
      mag_ff     <= mag_in;
      na_ff      <= na_in;
      nb_ff      <= nb_in;
      pp_ff      <= pp_in;
      pp_sel_ff  <= pp_sel_in;
      p_ff       <= p_in;
      d_ff       <= d_in;
      s_ff       <= s_in;
      tsh_ff     <= tsh_in;
      psh_ff     <= psh_in;
      trial_ff   <= trial_in;
      q_ff       <= q_in;
      deg_ff     <= deg_in;
      rsp_sim_ff <= rsp_sim_in;
      rsp_deg_ff <= rsp_deg_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_similarity = rsp_sim_ff;
   assign rsp_degenerate = rsp_deg_ff;

`ifndef SYNTHESIS
   a_q_clamped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD || state_ff == ST_CMP || state_ff == ST_RESULT)
         |-> !(q_ff[QW-1] && (|q_ff[QW-2:0])))
      else $error("quotient grew beyond one");
   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_deg_ff) |-> (rsp_sim_ff == '0))
      else $error("degenerate result with nonzero similarity");
   a_sim_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_sim_ff <= SimOne && rsp_sim_ff >= -SimOne))
      else $error("similarity outside plus or minus one");
`endif

endmodule

[hw/rtl/cosine_similarity_unit.sv]
// Cosine similarity unit: element pairs in on req_, one Q1.14 cosine per
// vector out on rsp_. Uses cos_sim_pkg, cos_sim_front, cos_sim_fifo and
// cos_sim_back.
//
// Each req_ beat carries one pair of Q1.14 elements; req_last_elem marks the
// final pair of a vector. The front end takes one beat per cycle, unless a last
// pair waits on a full queue, and keeps saturating sums of a*b, a*a and b*b.
// On the last pair the sums go into a two-entry queue and the sums clear, so
// the next vector can start at once. The back end handles one vector at a
// time: it loads the sums, forms the four-part products on its single 22x22
// multiplier, runs the fifteen trial steps of the quotient search and writes
// the result, so short vectors are paced by it, once the queue has filled,
// through req_ready. A vector with a zero norm skips the products and the
// search and gives similarity 0 with rsp_degenerate set.
// A stalled rsp_ beat holds in the output register; the back end then waits
// and the queue and front end fill behind it. Reset clears the sums, the
// queue and the output, and the block accepts beats the cycle after.
module cosine_similarity_unit #(
   parameter int ELEM_WIDTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_elem_a,
   input  logic signed [15:0] req_elem_b,
   input  logic               req_last_elem,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_similarity,
   output logic               rsp_degenerate
);
   import cos_sim_pkg::*;

   vec_sums_type push_data;
   vec_sums_type head;
   logic         push, pop, fifo_full, fifo_not_empty;

   cos_sim_front #(
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_elem_a    (req_elem_a),
      .req_elem_b    (req_elem_b),
      .req_last_elem (req_last_elem),
      .push          (push),
      .fifo_full     (fifo_full),
      .push_data     (push_data)
   );

   cos_sim_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .not_empty (fifo_not_empty),
      .full      (fifo_full)
   );

   cos_sim_back u_back (
      .clock          (clock),
      .reset          (reset),
      .fifo_valid     (fifo_not_empty),
      .fifo_head      (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_similarity (rsp_similarity),
      .rsp_degenerate (rsp_degenerate)
   );

endmodule
